// ===== hw/rtl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// shared types and constants for the huffman code bit packer
// ----------------------------------------------------------------------------
package hcbp_pkg;

   localparam int OP_W   = 2;
   localparam int SYM_W  = 8;
   localparam int CODE_W = 24;
   localparam int LEN_W  = 5;
   localparam int BYTE_W = 8;
   localparam int KIND_W = 2;

   // longest code the stored length field can describe
   localparam int LEN_LIMIT        = (1 << LEN_W) - 1;
   localparam int MAX_CODE_LEN_DEF = 24;
   localparam int TABLE_DEPTH      = 1 << SYM_W;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PARTIAL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code_word;
      logic [LEN_W-1:0]  code_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [KIND_W-1:0] byte_kind;
      logic              last;
   } rsp_type;

   // control of the shared shifter
   typedef struct packed {
      logic             left;
      logic [LEN_W-1:0] amount;
   } shift_ctl_type;

endpackage

// ===== hw/rtl/hcbp_ram.sv =====
// ----------------------------------------------------------------------------
// hcbp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/hcbp_shift.sv =====
// ----------------------------------------------------------------------------
// hcbp_shift
// shared barrel shifter, left for code append, right for byte extraction
// ----------------------------------------------------------------------------
module hcbp_shift #(
   parameter int DATA_W = 31
) (
   input  hcbp_pkg::shift_ctl_type ctl,
   input  logic [DATA_W-1:0]       data_in,
   output logic [DATA_W-1:0]       data_out
);

   import hcbp_pkg::*;

   always_comb begin
      if (ctl.left) begin
         data_out = data_in << ctl.amount;
      end else begin
         data_out = data_in >> ctl.amount;
      end
   end

endmodule

// ===== hw/rtl/huffman_code_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// huffman code lookup and msb-first bit packing into bytes
// ----------------------------------------------------------------------------
// load: no result; encode: one shifter pass to append, then one shifter pass
// per output byte, and no result when no byte completes; flush: two results,
// the partial byte and the unused-bit count. one transaction in flight at
// a time, a result register lets the next item in while the last result waits.
// synchronous reset clears the sequencer, accumulator, fill count and result
// valid; the code table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_unit #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hcbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hcbp_pkg::rsp_type rsp_data
);

   import hcbp_pkg::*;

   // longest code that can actually be stored
   localparam int LEN_CAP = (MAX_CODE_LEN > LEN_LIMIT) ? LEN_LIMIT : MAX_CODE_LEN;
   // up to seven pending bits plus one full code
   localparam int ACC_W   = LEN_CAP + BYTE_W - 1;
   localparam int FILL_W  = $clog2(ACC_W + 1);
   localparam int ENTRY_W = CODE_W + LEN_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_EMIT,
      ST_PART,
      ST_COUNT
   } state_type;

   state_type            state_ff, state_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 req_accept;
   logic                 out_free;

   // table port signals
   logic                 tbl_wr_en;
   logic [ENTRY_W-1:0]   tbl_wr_data;
   logic                 tbl_rd_en;
   logic [ENTRY_W-1:0]   tbl_rd_data;
   logic [LEN_W-1:0]     load_len;
   logic [CODE_W-1:0]    load_code;
   logic [LEN_W-1:0]     ent_len;
   logic [CODE_W-1:0]    ent_code;

   // shared shifter
   shift_ctl_type        sh_ctl;
   logic [ACC_W-1:0]     sh_out;

   // byte extraction helpers
   logic [FILL_W-1:0]    rem_fill;
   logic [ACC_W-1:0]     rem_mask;
   logic [ACC_W-1:0]     fill_mask;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // load path: saturate the length and drop code bits above it
   // ---------------------------------------------------------------------
   always_comb begin
      if (32'(req_data.code_length) > LEN_CAP) begin
         load_len = LEN_W'(LEN_CAP);
      end else begin
         load_len = req_data.code_length;
      end
      for (int i = 0; i < CODE_W; i++) begin
         load_code[i] = req_data.code_word[i] && (32'(i) < 32'(load_len));
      end
   end

   assign tbl_wr_en   = req_accept && (req_data.op == OP_LOAD);
   assign tbl_wr_data = {load_code, load_len};
   // encode reads the entry at acceptance, data is ready in the append cycle
   assign tbl_rd_en   = req_accept && (req_data.op == OP_ENCODE);

   hcbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (req_data.symbol),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (req_data.symbol),
      .rd_data (tbl_rd_data)
   );

   assign ent_len  = tbl_rd_data[LEN_W-1:0];
   assign ent_code = tbl_rd_data[ENTRY_W-1:LEN_W];

   // ---------------------------------------------------------------------
   // shifter control: left by code length when appending, right by
   // (fill - 8) when taking the oldest byte off the top
   // ---------------------------------------------------------------------
   assign rem_fill = fill_ff - FILL_W'(BYTE_W);

   always_comb begin
      sh_ctl.left = (state_ff == ST_APPEND);
      if (state_ff == ST_APPEND) begin
         sh_ctl.amount = ent_len;
      end else begin
         sh_ctl.amount = LEN_W'(rem_fill);
      end
   end

   hcbp_shift #(
      .DATA_W (ACC_W)
   ) u_shift (
      .ctl      (sh_ctl),
      .data_in  (acc_ff),
      .data_out (sh_out)
   );

   // masks of the bits still pending after and before an extraction
   always_comb begin
      for (int i = 0; i < ACC_W; i++) begin
         rem_mask[i]  = (FILL_W'(i) < rem_fill);
         fill_mask[i] = (FILL_W'(i) < fill_ff);
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      fill_in      = fill_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.op)
                  OP_ENCODE: state_in = ST_APPEND;
                  OP_FLUSH:  state_in = ST_PART;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end

         ST_APPEND: begin
            acc_in   = sh_out | ACC_W'(ent_code);
            fill_in  = fill_ff + FILL_W'(ent_len);
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (fill_ff < FILL_W'(BYTE_W)) begin
               // nothing (more) to emit
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_in.out_byte  = sh_out[BYTE_W-1:0];
               rsp_in.byte_kind = KIND_DATA;
               rsp_in.last      = (rem_fill < FILL_W'(BYTE_W));
               rsp_valid_in     = 1'b1;
               acc_in           = acc_ff & rem_mask;
               fill_in          = rem_fill;
               if (rem_fill < FILL_W'(BYTE_W)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_PART: begin
            // pending bits are already right-aligned and zero above fill
            if (out_free) begin
               rsp_in.out_byte  = acc_ff[BYTE_W-1:0];
               rsp_in.byte_kind = KIND_PARTIAL;
               rsp_in.last      = 1'b0;
               rsp_valid_in     = 1'b1;
               state_in         = ST_COUNT;
            end
         end

         ST_COUNT: begin
            if (out_free) begin
               rsp_in.out_byte  = BYTE_W'(BYTE_W) - BYTE_W'(fill_ff);
               rsp_in.byte_kind = KIND_UNUSED;
               rsp_in.last      = 1'b1;
               rsp_valid_in     = 1'b1;
               acc_in           = '0;
               fill_in          = '0;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------

   // between items fewer than eight bits are pending
   a_fill_below_byte: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (fill_ff < FILL_W'(BYTE_W)))
      else $error("fill count not below one byte while idle");

   // no stray bits above the fill count
   a_acc_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((acc_ff & ~fill_mask) == '0))
      else $error("accumulator holds bits above the fill count");

   // the unused-bit count always closes a flush transaction
   a_count_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.byte_kind == KIND_UNUSED)) |-> rsp_ff.last)
      else $error("unused-bit count not marked last");

   // flush leaves an empty accumulator
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT && out_free) |=> (fill_ff == '0 && acc_ff == '0))
      else $error("accumulator not cleared after flush");

endmodule
